// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TKW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset cycles included.
`define TKW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tkw_pkg.sv =====
package tkw_pkg;

    localparam int MAX_SLOTS    = 4;
    localparam int VERTEX_COUNT = 1024;

    localparam int CMD_W      = 2;
    localparam int VIDX_W     = 10;
    localparam int BONE_W     = 8;
    localparam int WT_W       = 16;
    localparam int FRAC_BITS  = 15;
    localparam int SEL_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int SIU_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W      = WT_W + $clog2(MAX_SLOTS);
    localparam int VADDR_W    = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int DIV_CNT_W  = $clog2(WT_W);

    localparam logic [SUM_W-1:0] ONE_Q15 = SUM_W'(1) << FRAC_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_ATTACH    = 2'd0,
        CMD_NORMALIZE = 2'd1,
        CMD_READ      = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE     = 2'd0,
        STS_REJECT   = 2'd1,
        STS_NO_SLOTS = 2'd2,
        STS_RANGE    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOTS_IN_USE = 1'd0,
        CFG_TIE_ACCEPTS  = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_WRBACK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [MAX_SLOTS-1:0][BONE_W-1:0] bones;
        logic [MAX_SLOTS-1:0][WT_W-1:0]   weights;
    } t_entry;

endpackage

// ===== hdl/tkw_div.sv =====
module tkw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tkw_pkg::WT_W-1:0]    i_num,
    input  logic [tkw_pkg::SUM_W-1:0]   i_den,
    output logic                        o_done,
    output logic [tkw_pkg::WT_W-1:0]    o_quot
);

    // Restoring divide of (num << FRAC_BITS) by den, one quotient bit a cycle.
    // num never exceeds den, so the quotient fits WT_W bits and only the
    // low WT_W dividend bits need stepping.

    logic                           r_busy;
    logic                           r_done;
    logic [tkw_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [tkw_pkg::SUM_W-1:0]      r_rem;
    logic [tkw_pkg::SUM_W-1:0]      r_den;
    logic [tkw_pkg::WT_W-1:0]       r_low;
    logic [tkw_pkg::WT_W-1:0]       r_quot;

    logic [tkw_pkg::SUM_W:0]        trial;
    logic                           ge;
    logic [tkw_pkg::SUM_W:0]        diff;

    always_comb begin
        trial = {r_rem, r_low[tkw_pkg::WT_W-1]};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tkw_pkg::DIV_CNT_W'(tkw_pkg::WT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= tkw_pkg::SUM_W'(i_num >> (tkw_pkg::WT_W - tkw_pkg::FRAC_BITS));
            r_low  <= i_num << tkw_pkg::FRAC_BITS;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[tkw_pkg::SUM_W-1:0] : trial[tkw_pkg::SUM_W-1:0];
            r_low  <= r_low << 1;
            r_quot <= {r_quot[tkw_pkg::WT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/topk_weight_slot_insert_unit.sv =====
// Channel   Handshake                  Payload
// -------   -------------------------  ------------------------------------------------
// input     i_in_valid / o_in_ready    i_command, i_vertex_index, i_bone_id,
//                                      i_new_weight, i_slot_select
// output    o_out_valid / i_out_ready  o_status, o_slot_bone, o_slot_weight
// config    i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One item at a time. Read, attach and a normalize of a zero or unit sum run
// S_EXEC, then S_RESULT; range and no-slot errors and unknown commands go straight
// to S_RESULT. Other normalizes run S_DIV per active slot on the one-bit-per-cycle
// divider the slots share, then S_WRBACK. After reset the entry memory is cleared
// one entry a cycle with o_in_ready low. A finished result waits in the output
// register while the next item is taken; a held result stalls only the one behind it.
module topk_weight_slot_insert_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tkw_pkg::CMD_W-1:0]       i_command,
    input  logic [tkw_pkg::VIDX_W-1:0]      i_vertex_index,
    input  logic [tkw_pkg::BONE_W-1:0]      i_bone_id,
    input  logic [tkw_pkg::WT_W-1:0]        i_new_weight,
    input  logic [tkw_pkg::SEL_W-1:0]       i_slot_select,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tkw_pkg::STATUS_W-1:0]    o_status,
    output logic [tkw_pkg::BONE_W-1:0]      o_slot_bone,
    output logic [tkw_pkg::WT_W-1:0]        o_slot_weight,
    input  logic                            i_cfg_we,
    input  logic [tkw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tkw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // ---------------------------------------------------------------- config
    logic [tkw_pkg::SIU_W-1:0]  r_slots_in_use;
    logic                       r_tie_accepts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= '0;
            r_tie_accepts  <= 1'b0;
        end else if (i_cfg_we) begin
            case (tkw_pkg::t_cfg_reg'(i_cfg_idx))
                tkw_pkg::CFG_SLOTS_IN_USE: r_slots_in_use <= i_cfg_data[tkw_pkg::SIU_W-1:0];
                tkw_pkg::CFG_TIE_ACCEPTS:  r_tie_accepts  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [tkw_pkg::SLOT_CNT_W-1:0] n_act;
    logic [tkw_pkg::SLOT_W-1:0]     last;

    always_comb begin
        if (32'(r_slots_in_use) > tkw_pkg::MAX_SLOTS) begin
            n_act = tkw_pkg::SLOT_CNT_W'(tkw_pkg::MAX_SLOTS);
        end else begin
            n_act = tkw_pkg::SLOT_CNT_W'(r_slots_in_use);
        end
        last = tkw_pkg::SLOT_W'(n_act - 1'b1);
    end

    // ---------------------------------------------------------------- memory
    tkw_pkg::t_entry            mem [tkw_pkg::VERTEX_COUNT];
    tkw_pkg::t_entry            r_rd_data;
    logic                       rd_en;
    logic                       mem_we;
    logic [tkw_pkg::VADDR_W-1:0] mem_waddr;
    tkw_pkg::t_entry            mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[tkw_pkg::VADDR_W'(i_vertex_index)];
        end
    end

    // ---------------------------------------------------------------- state
    tkw_pkg::t_state            r_state, n_state;
    logic [tkw_pkg::VADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic                       r_div_start, n_div_start;
    logic                       r_out_valid, n_out_valid;

    tkw_pkg::t_cmd              r_cmd, n_cmd;
    logic [tkw_pkg::VADDR_W-1:0] r_vaddr, n_vaddr;
    logic [tkw_pkg::BONE_W-1:0] r_bone, n_bone;
    logic [tkw_pkg::WT_W-1:0]   r_wt, n_wt;
    logic [tkw_pkg::SLOT_W-1:0] r_sel, n_sel;
    logic [tkw_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [tkw_pkg::SUM_W-1:0]  r_sum, n_sum;
    tkw_pkg::t_entry            r_entry, n_entry;
    tkw_pkg::t_status           r_res_status, n_res_status;
    logic [tkw_pkg::BONE_W-1:0] r_res_bone, n_res_bone;
    logic [tkw_pkg::WT_W-1:0]   r_res_wt, n_res_wt;
    tkw_pkg::t_status           r_out_status, n_out_status;
    logic [tkw_pkg::BONE_W-1:0] r_out_bone, n_out_bone;
    logic [tkw_pkg::WT_W-1:0]   r_out_wt, n_out_wt;

    logic                       div_done;
    logic [tkw_pkg::WT_W-1:0]   div_quot;

    tkw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_entry.weights[r_slot]),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ---------------------------------------------------------------- attach
    tkw_pkg::t_entry            att_entry;
    logic                       att_reject;
    logic [tkw_pkg::SLOT_W-1:0] pos;
    logic                       stop;
    logic                       room;

    always_comb begin
        att_entry  = r_rd_data;
        att_reject = 1'b0;
        pos        = last;
        stop       = 1'b0;
        room = (r_rd_data.bones[last] == '0) || (r_rd_data.weights[last] < r_wt) ||
               (r_tie_accepts && (r_rd_data.weights[last] == r_wt));
        // new pair lands at pos after passing empty slots and lower weights
        for (int k = tkw_pkg::MAX_SLOTS - 1; k >= 1; k--) begin
            if (!stop && (k <= int'(last))) begin
                if ((r_rd_data.bones[k-1] == '0) || (r_rd_data.weights[k-1] < r_wt)) begin
                    pos = tkw_pkg::SLOT_W'(k - 1);
                end else begin
                    stop = 1'b1;
                end
            end
        end
        if (r_bone == '0) begin
            att_reject = 1'b1;
        end else if (r_rd_data.bones[0] == '0) begin
            att_entry.bones[0]   = r_bone;
            att_entry.weights[0] = r_wt;
        end else if (!room) begin
            att_reject = 1'b1;
        end else begin
            for (int j = 0; j < tkw_pkg::MAX_SLOTS; j++) begin
                if (j == int'(pos)) begin
                    att_entry.bones[j]   = r_bone;
                    att_entry.weights[j] = r_wt;
                end else if ((j > int'(pos)) && (j <= int'(last))) begin
                    att_entry.bones[j]   = r_rd_data.bones[j-1];
                    att_entry.weights[j] = r_rd_data.weights[j-1];
                end
            end
        end
    end

    logic [tkw_pkg::SUM_W-1:0]  wsum;

    always_comb begin
        wsum = '0;
        for (int j = 0; j < tkw_pkg::MAX_SLOTS; j++) begin
            if (j < int'(n_act)) begin
                wsum = wsum + tkw_pkg::SUM_W'(r_rd_data.weights[j]);
            end
        end
    end

    // ---------------------------------------------------------------- control
    logic in_xfer;
    logic out_free;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_div_start  = 1'b0;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_vaddr      = r_vaddr;
        n_bone       = r_bone;
        n_wt         = r_wt;
        n_sel        = r_sel;
        n_slot       = r_slot;
        n_sum        = r_sum;
        n_entry      = r_entry;
        n_res_status = r_res_status;
        n_res_bone   = r_res_bone;
        n_res_wt     = r_res_wt;
        n_out_status = r_out_status;
        n_out_bone   = r_out_bone;
        n_out_wt     = r_out_wt;
        o_in_ready   = 1'b0;
        rd_en        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_vaddr;
        mem_wdata    = att_entry;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tkw_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == tkw_pkg::VADDR_W'(tkw_pkg::VERTEX_COUNT - 1)) begin
                    n_state = tkw_pkg::S_IDLE;
                end
            end
            tkw_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                n_cmd        = tkw_pkg::t_cmd'(i_command);
                n_vaddr      = tkw_pkg::VADDR_W'(i_vertex_index);
                n_bone       = i_bone_id;
                n_wt         = i_new_weight;
                n_sel        = tkw_pkg::SLOT_W'(i_slot_select);
                n_res_status = tkw_pkg::STS_DONE;
                n_res_bone   = '0;
                n_res_wt     = '0;
                if (in_xfer) begin
                    n_state = tkw_pkg::S_RESULT;
                    case (tkw_pkg::t_cmd'(i_command))
                        tkw_pkg::CMD_ATTACH, tkw_pkg::CMD_NORMALIZE: begin
                            if (n_act == '0) begin
                                n_res_status = tkw_pkg::STS_NO_SLOTS;
                            end else if (32'(i_vertex_index) >= tkw_pkg::VERTEX_COUNT) begin
                                n_res_status = tkw_pkg::STS_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = tkw_pkg::S_EXEC;
                            end
                        end
                        tkw_pkg::CMD_READ: begin
                            if ((32'(i_vertex_index) >= tkw_pkg::VERTEX_COUNT) ||
                                (32'(i_slot_select) >= tkw_pkg::MAX_SLOTS)) begin
                                n_res_status = tkw_pkg::STS_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = tkw_pkg::S_EXEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tkw_pkg::S_EXEC: begin
                n_state = tkw_pkg::S_RESULT;
                case (r_cmd)
                    tkw_pkg::CMD_ATTACH: begin
                        if (att_reject) begin
                            n_res_status = tkw_pkg::STS_REJECT;
                        end else begin
                            mem_we = 1'b1;
                        end
                    end
                    tkw_pkg::CMD_NORMALIZE: begin
                        // already unit sum or all zero: leave the entry alone
                        if ((wsum != '0) && (wsum != tkw_pkg::ONE_Q15)) begin
                            n_entry     = r_rd_data;
                            n_sum       = wsum;
                            n_slot      = '0;
                            n_div_start = 1'b1;
                            n_state     = tkw_pkg::S_DIV;
                        end
                    end
                    tkw_pkg::CMD_READ: begin
                        n_res_bone = r_rd_data.bones[r_sel];
                        n_res_wt   = r_rd_data.weights[r_sel];
                    end
                    default: ;
                endcase
            end
            tkw_pkg::S_DIV: begin
                if (div_done) begin
                    n_entry.weights[r_slot] = div_quot;
                    if (r_slot == last) begin
                        n_state = tkw_pkg::S_WRBACK;
                    end else begin
                        n_slot      = r_slot + 1'b1;
                        n_div_start = 1'b1;
                    end
                end
            end
            tkw_pkg::S_WRBACK: begin
                mem_we    = 1'b1;
                mem_wdata = r_entry;
                n_state   = tkw_pkg::S_RESULT;
            end
            tkw_pkg::S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_bone   = r_res_bone;
                    n_out_wt     = r_res_wt;
                    n_state      = tkw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tkw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkw_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_vaddr      <= n_vaddr;
        r_bone       <= n_bone;
        r_wt         <= n_wt;
        r_sel        <= n_sel;
        r_slot       <= n_slot;
        r_sum        <= n_sum;
        r_entry      <= n_entry;
        r_res_status <= n_res_status;
        r_res_bone   <= n_res_bone;
        r_res_wt     <= n_res_wt;
        r_out_status <= n_out_status;
        r_out_bone   <= n_out_bone;
        r_out_wt     <= n_out_wt;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_bone   = r_out_bone;
    assign o_slot_weight = r_out_wt;

endmodule

// ===== hdl/tkw_chk.sv =====
`include "assert_macros.svh"

module tkw_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [tkw_pkg::STATUS_W-1:0]    o_status,
    input  logic [tkw_pkg::BONE_W-1:0]      o_slot_bone,
    input  logic [tkw_pkg::WT_W-1:0]        o_slot_weight
);

    // result held until its transfer
    `TKW_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_slot_bone) && $stable(o_slot_weight), "result dropped or changed while stalled")

    // reset leaves nothing to transfer on either side
    `TKW_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid && !o_in_ready, "channel active after reset")

    // one item in flight: the input is closed in the cycle after an input transfer
    `TKW_ASSERT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "second item taken while busy")

    // only a completed read carries slot contents
    `TKW_ASSERT(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status != tkw_pkg::STS_DONE) |-> (o_slot_bone == '0) && (o_slot_weight == '0), "slot data on a failed command")

endmodule

bind topk_weight_slot_insert_unit tkw_chk u_tkw_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_slot_bone   (o_slot_bone),
    .o_slot_weight (o_slot_weight)
);
